// ===== sv/urm_pkg.sv =====
// Package for the 16550-style UART register model.
// Holds request and register codes, FIFO sizing and channel payload types.
// No dependencies.
package urm_pkg;

  // receive FIFO sizing
  localparam int RX_DEPTH = 64;
  localparam int ADDR_W   = $clog2(RX_DEPTH);
  localparam int FILL_W   = $clog2(RX_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE_ACTIVE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSRQ_ENABLE   = 1'd1;

  // request types
  localparam logic [2:0] REQ_BUS_WRITE = 3'd0;
  localparam logic [2:0] REQ_BUS_READ  = 3'd1;
  localparam logic [2:0] REQ_POLL      = 3'd2;
  localparam logic [2:0] REQ_HOST_BYTE = 3'd3;
  localparam logic [2:0] REQ_SYSRQ     = 3'd4;

  // register offsets
  localparam logic [2:0] OFF_RBR_THR = 3'd0;
  localparam logic [2:0] OFF_IER     = 3'd1;
  localparam logic [2:0] OFF_IIR_FCR = 3'd2;
  localparam logic [2:0] OFF_LCR     = 3'd3;
  localparam logic [2:0] OFF_MCR     = 3'd4;
  localparam logic [2:0] OFF_LSR     = 3'd5;
  localparam logic [2:0] OFF_MSR     = 3'd6;
  localparam logic [2:0] OFF_SCR     = 3'd7;

  // register bits and constants
  localparam logic [7:0] LSR_DR     = 8'h01;
  localparam logic [7:0] LSR_BI     = 8'h10;
  localparam logic [7:0] LSR_THRE   = 8'h20;
  localparam logic [7:0] LSR_TEMT   = 8'h40;
  localparam logic [7:0] FCR_CLR_RX = 8'h02;
  localparam logic [7:0] FCR_CLR_TX = 8'h04;
  localparam logic [7:0] MSR_CONST  = 8'hB0;
  localparam logic [7:0] IIR_FIFO   = 8'hC0;
  localparam logic [7:0] IIR_NONE   = 8'h01;
  localparam logic [7:0] IIR_RDA    = 8'h04;
  localparam logic [7:0] IIR_THRE   = 8'h02;
  localparam logic [7:0] MCR_RESET  = 8'h08;
  localparam int LCR_DLAB_BIT = 7;
  localparam int MCR_LOOP_BIT = 4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] host_byte;
  } urm_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_level;
  } urm_rsp_t;

endpackage

// ===== sv/urm_if.sv =====
// Valid/ready channel interfaces for the UART register model.
// Depends on urm_pkg for the payload types.
interface urm_req_if;
  logic              valid;
  logic              ready;
  urm_pkg::urm_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface urm_rsp_if;
  logic              valid;
  logic              ready;
  urm_pkg::urm_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/uart_16550_register_model.sv =====
// Response in the cycle after the request; one request taken every cycle.
// The request is evaluated in one combinational pass against the register
// state and the prefetched receive FIFO head, and the response is registered.
// Throughput is limited only by response backpressure.
// Reset (synchronous, rst_n low) restores register defaults and empties the
// FIFO at once; FIFO storage itself is not cleared and needs no sweep.
module uart_16550_register_model (
  input  logic                           clk,
  input  logic                           rst_n,
  urm_req_if.sink                        in_ch,
  urm_rsp_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [urm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                           cfg_wdata
);

  // configuration
  logic console_active_r, sysrq_enable_r;

  // register file state
  logic [7:0] dll_r, dll_nxt, dlm_r, dlm_nxt;
  logic [3:0] ier_r, ier_nxt;
  logic [7:0] fcr_r, fcr_nxt, lcr_r, lcr_nxt, mcr_r, mcr_nxt;
  logic [7:0] lsr_r, lsr_nxt, scr_r, scr_nxt, iir_r, iir_nxt;
  logic [urm_pkg::FILL_W-1:0] fill_r, fill_nxt, taken_r, taken_nxt;
  logic [7:0] psys_r, psys_nxt;
  logic       win_r, win_nxt;

  // fifo storage and prefetched head entry
  logic [7:0] rx_mem [urm_pkg::RX_DEPTH];
  logic [7:0] head_r;
  logic       mem_we;
  logic [urm_pkg::ADDR_W-1:0] mem_waddr, rd_addr;
  logic [7:0] mem_wdata;

  // response register
  logic              out_valid_r;
  urm_pkg::urm_rsp_t out_r;
  urm_pkg::urm_rsp_t rsp;

  // per-request control
  logic       accept;
  logic       dlab;
  logic       push_req;
  logic [7:0] push_data;
  logic       close_if_full;
  logic       do_refresh;
  logic [7:0] causes;

  // no request is taken while reset is held
  assign in_ch.ready  = rst_n && (!out_valid_r || out_ch.ready);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign dlab         = lcr_r[urm_pkg::LCR_DLAB_BIT];

  // request evaluation
  always_comb begin
    dll_nxt   = dll_r;
    dlm_nxt   = dlm_r;
    ier_nxt   = ier_r;
    fcr_nxt   = fcr_r;
    lcr_nxt   = lcr_r;
    mcr_nxt   = mcr_r;
    lsr_nxt   = lsr_r;
    scr_nxt   = scr_r;
    iir_nxt   = iir_r;
    fill_nxt  = fill_r;
    taken_nxt = taken_r;
    psys_nxt  = psys_r;
    win_nxt   = win_r;
    rsp       = '0;
    push_req  = 1'b0;
    push_data = 8'h00;
    close_if_full = 1'b0;
    do_refresh    = 1'b0;
    causes        = 8'h00;
    mem_we    = 1'b0;
    mem_waddr = fill_r[urm_pkg::ADDR_W-1:0];
    mem_wdata = 8'h00;

    if (accept) begin
      case (in_ch.data.req_type)
        urm_pkg::REQ_BUS_WRITE: begin
          win_nxt    = 1'b0;
          do_refresh = 1'b1;
          case (in_ch.data.reg_offset)
            urm_pkg::OFF_RBR_THR: begin
              if (dlab) begin
                dll_nxt = in_ch.data.write_data;
              end else if (mcr_r[urm_pkg::MCR_LOOP_BIT]) begin
                push_req  = 1'b1;
                push_data = in_ch.data.write_data;
              end else begin
                rsp.tx_valid = 1'b1;
                rsp.tx_byte  = in_ch.data.write_data;
                lsr_nxt      = lsr_nxt | urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
              end
            end
            urm_pkg::OFF_IER: begin
              if (dlab) dlm_nxt = in_ch.data.write_data;
              else      ier_nxt = in_ch.data.write_data[3:0];
            end
            urm_pkg::OFF_IIR_FCR: fcr_nxt = in_ch.data.write_data;
            urm_pkg::OFF_LCR:     lcr_nxt = in_ch.data.write_data;
            urm_pkg::OFF_MCR:     mcr_nxt = in_ch.data.write_data;
            urm_pkg::OFF_SCR:     scr_nxt = in_ch.data.write_data;
            default: ;
          endcase
        end
        urm_pkg::REQ_BUS_READ: begin
          win_nxt    = 1'b0;
          do_refresh = 1'b1;
          case (in_ch.data.reg_offset)
            urm_pkg::OFF_RBR_THR: begin
              if (dlab) begin
                rsp.read_data = dll_r;
              end else if (taken_r >= fill_r) begin
                rsp.read_data = 8'h00;
              end else if ((lsr_r & urm_pkg::LSR_BI) != 8'h00) begin
                // break marker reads as zero once
                lsr_nxt = lsr_r & ~urm_pkg::LSR_BI;
              end else begin
                rsp.read_data = head_r;
                taken_nxt     = taken_r + 1'b1;
                if (taken_nxt == fill_r) begin
                  lsr_nxt   = lsr_r & ~urm_pkg::LSR_DR;
                  fill_nxt  = '0;
                  taken_nxt = '0;
                end
              end
            end
            urm_pkg::OFF_IER:     rsp.read_data = dlab ? dlm_r : {4'h0, ier_r};
            urm_pkg::OFF_IIR_FCR: rsp.read_data = iir_r | urm_pkg::IIR_FIFO;
            urm_pkg::OFF_LCR:     rsp.read_data = lcr_r;
            urm_pkg::OFF_MCR:     rsp.read_data = mcr_r;
            urm_pkg::OFF_LSR:     rsp.read_data = lsr_r;
            urm_pkg::OFF_MSR:     rsp.read_data = urm_pkg::MSR_CONST;
            default:              rsp.read_data = scr_r;
          endcase
        end
        urm_pkg::REQ_POLL: begin
          win_nxt    = 1'b0;
          do_refresh = 1'b1;
          if (!mcr_r[urm_pkg::MCR_LOOP_BIT] && ((lsr_r & urm_pkg::LSR_DR) == 8'h00)
              && (fill_r == '0)) begin
            if (sysrq_enable_r && (psys_r != 8'h00)) begin
              lsr_nxt   = lsr_r | urm_pkg::LSR_DR | urm_pkg::LSR_BI;
              push_req  = 1'b1;
              push_data = psys_r;
              psys_nxt  = 8'h00;
            end else if (console_active_r) begin
              win_nxt = 1'b1;
            end
          end
        end
        urm_pkg::REQ_HOST_BYTE: begin
          if (win_r) begin
            push_req      = 1'b1;
            push_data     = in_ch.data.host_byte;
            close_if_full = 1'b1;
            do_refresh    = 1'b1;
          end
        end
        urm_pkg::REQ_SYSRQ: psys_nxt = in_ch.data.host_byte;
        default: ;
      endcase
    end

    // push into the receive fifo, dropped when full
    if (push_req && (fill_r < urm_pkg::FILL_W'(urm_pkg::RX_DEPTH))) begin
      mem_we    = 1'b1;
      mem_wdata = push_data;
      fill_nxt  = fill_r + 1'b1;
      lsr_nxt   = lsr_nxt | urm_pkg::LSR_DR;
    end
    if (close_if_full && (fill_nxt >= urm_pkg::FILL_W'(urm_pkg::RX_DEPTH))) begin
      win_nxt = 1'b0;
    end

    // self-clearing fifo resets, then interrupt identity
    if (do_refresh) begin
      if ((fcr_nxt & urm_pkg::FCR_CLR_RX) != 8'h00) begin
        fcr_nxt   = fcr_nxt & ~urm_pkg::FCR_CLR_RX;
        fill_nxt  = '0;
        taken_nxt = '0;
        lsr_nxt   = lsr_nxt & ~urm_pkg::LSR_DR;
      end
      if ((fcr_nxt & urm_pkg::FCR_CLR_TX) != 8'h00) begin
        fcr_nxt = fcr_nxt & ~urm_pkg::FCR_CLR_TX;
        lsr_nxt = lsr_nxt | urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
      end
      if (ier_nxt[0] && ((lsr_nxt & urm_pkg::LSR_DR) != 8'h00)) begin
        causes = causes | urm_pkg::IIR_RDA;
      end
      if (ier_nxt[1] && ((lsr_nxt & urm_pkg::LSR_TEMT) != 8'h00)) begin
        causes = causes | urm_pkg::IIR_THRE;
      end
      iir_nxt = (causes != 8'h00) ? causes : urm_pkg::IIR_NONE;
      if (!ier_nxt[1]) begin
        lsr_nxt = lsr_nxt | urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
      end
    end

    rsp.irq_level = !iir_nxt[0];
  end

  assign rd_addr = taken_nxt[urm_pkg::ADDR_W-1:0];

  // fifo storage with head prefetch and write bypass
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rx_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == rd_addr)) begin
      head_r <= mem_wdata;
    end else begin
      head_r <= rx_mem[rd_addr];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      console_active_r <= 1'b1;
      sysrq_enable_r   <= 1'b1;
      dll_r   <= 8'h00;
      dlm_r   <= 8'h00;
      ier_r   <= 4'h0;
      fcr_r   <= 8'h00;
      lcr_r   <= 8'h00;
      mcr_r   <= urm_pkg::MCR_RESET;
      lsr_r   <= urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
      scr_r   <= 8'h00;
      iir_r   <= urm_pkg::IIR_NONE;
      fill_r  <= '0;
      taken_r <= '0;
      psys_r  <= 8'h00;
      win_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == urm_pkg::CFG_CONSOLE_ACTIVE)) begin
        console_active_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == urm_pkg::CFG_SYSRQ_ENABLE)) begin
        sysrq_enable_r <= cfg_wdata;
      end
      dll_r   <= dll_nxt;
      dlm_r   <= dlm_nxt;
      ier_r   <= ier_nxt;
      fcr_r   <= fcr_nxt;
      lcr_r   <= lcr_nxt;
      mcr_r   <= mcr_nxt;
      lsr_r   <= lsr_nxt;
      scr_r   <= scr_nxt;
      iir_r   <= iir_nxt;
      fill_r  <= fill_nxt;
      taken_r <= taken_nxt;
      psys_r  <= psys_nxt;
      win_r   <= win_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= rsp;
    end
  end

endmodule

// ===== bench/urm_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the UART register model: predicts each response from
// the accepted requests and the configuration writes, then compares.
// Depends on urm_pkg for codes, register bits and payload types.
module urm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  urm_pkg::urm_req_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  urm_pkg::urm_rsp_t             out_data,
  input  logic                          cfg_we,
  input  logic [urm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);

  // shadow copy of the register file and configuration
  logic       console_en, sysrq_en;
  logic [7:0] dll, dlm, fcr, lcr, mcr, lsr, scr, iir;
  logic [3:0] ier;
  logic [7:0] rx_mem [urm_pkg::RX_DEPTH];
  int         rx_count, rx_head;
  logic [7:0] sysrq_byte;
  logic       window_open;

  urm_pkg::urm_rsp_t expected_rsp [$];
  int         errors = 0;
  int         n_checked = 0;

  task automatic report(input string what, input logic [7:0] exp_v, input logic [7:0] got_v);
    $display("%0t mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
    errors++;
  endtask

  function automatic void shadow_reset();
    console_en  = 1'b1;
    sysrq_en    = 1'b1;
    dll         = '0;
    dlm         = '0;
    ier         = '0;
    fcr         = '0;
    lcr         = '0;
    mcr         = urm_pkg::MCR_RESET;
    lsr         = urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
    scr         = '0;
    iir         = urm_pkg::IIR_NONE;
    rx_count    = 0;
    rx_head     = 0;
    sysrq_byte  = '0;
    window_open = 1'b0;
    for (int i = 0; i < urm_pkg::RX_DEPTH; i++) rx_mem[i] = '0;
  endfunction

  // bytes past a full FIFO are dropped
  function automatic void rx_push(input logic [7:0] b);
    if (rx_count < urm_pkg::RX_DEPTH) begin
      rx_mem[rx_count] = b;
      rx_count++;
      lsr |= urm_pkg::LSR_DR;
    end
  endfunction

  // pending FIFO clears, then interrupt identity
  function automatic void irq_update();
    logic [7:0] causes;
    causes = '0;
    if ((fcr & urm_pkg::FCR_CLR_RX) != 0) begin
      fcr &= ~urm_pkg::FCR_CLR_RX;
      rx_count = 0;
      rx_head  = 0;
      lsr &= ~urm_pkg::LSR_DR;
    end
    if ((fcr & urm_pkg::FCR_CLR_TX) != 0) begin
      fcr &= ~urm_pkg::FCR_CLR_TX;
      lsr |= urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
    end
    if (ier[0] && (lsr & urm_pkg::LSR_DR) != 0) causes |= urm_pkg::IIR_RDA;
    if (ier[1] && (lsr & urm_pkg::LSR_TEMT) != 0) causes |= urm_pkg::IIR_THRE;
    iir = (causes != 0) ? causes : urm_pkg::IIR_NONE;
    if (!ier[1]) lsr |= urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
  endfunction

  // receive buffer read: empty gives 0, a pending break gives 0 once
  function automatic logic [7:0] rx_pop();
    logic [7:0] v;
    if (rx_head >= rx_count) return '0;
    if ((lsr & urm_pkg::LSR_BI) != 0) begin
      lsr &= ~urm_pkg::LSR_BI;
      return '0;
    end
    v = rx_mem[rx_head];
    rx_head++;
    if (rx_head == rx_count) begin
      lsr &= ~urm_pkg::LSR_DR;
      rx_count = 0;
      rx_head  = 0;
    end
    return v;
  endfunction

  function automatic urm_pkg::urm_rsp_t predict_rsp(input urm_pkg::urm_req_t r);
    urm_pkg::urm_rsp_t rsp;
    logic     dlab, loop;
    rsp  = '0;
    dlab = lcr[urm_pkg::LCR_DLAB_BIT];
    loop = mcr[urm_pkg::MCR_LOOP_BIT];
    case (r.req_type)
      urm_pkg::REQ_BUS_WRITE: begin
        window_open = 1'b0;
        case (r.reg_offset)
          urm_pkg::OFF_RBR_THR: begin
            if (dlab) dll = r.write_data;
            else if (loop) rx_push(r.write_data);
            else begin
              rsp.tx_valid = 1'b1;
              rsp.tx_byte  = r.write_data;
              lsr |= urm_pkg::LSR_TEMT | urm_pkg::LSR_THRE;
            end
          end
          urm_pkg::OFF_IER: begin
            if (dlab) dlm = r.write_data;
            else ier = r.write_data[3:0];
          end
          urm_pkg::OFF_IIR_FCR: fcr = r.write_data;
          urm_pkg::OFF_LCR:     lcr = r.write_data;
          urm_pkg::OFF_MCR:     mcr = r.write_data;
          urm_pkg::OFF_SCR:     scr = r.write_data;
          default: ;
        endcase
        irq_update();
      end
      urm_pkg::REQ_BUS_READ: begin
        window_open = 1'b0;
        case (r.reg_offset)
          urm_pkg::OFF_RBR_THR: rsp.read_data = dlab ? dll : rx_pop();
          urm_pkg::OFF_IER:     rsp.read_data = dlab ? dlm : {4'b0, ier};
          urm_pkg::OFF_IIR_FCR: rsp.read_data = iir | urm_pkg::IIR_FIFO;
          urm_pkg::OFF_LCR:     rsp.read_data = lcr;
          urm_pkg::OFF_MCR:     rsp.read_data = mcr;
          urm_pkg::OFF_LSR:     rsp.read_data = lsr;
          urm_pkg::OFF_MSR:     rsp.read_data = urm_pkg::MSR_CONST;
          default:              rsp.read_data = scr;
        endcase
        irq_update();
      end
      urm_pkg::REQ_POLL: begin
        window_open = 1'b0;
        if (!loop && (lsr & urm_pkg::LSR_DR) == 0 && rx_count == 0) begin
          if (sysrq_en && sysrq_byte != 0) begin
            lsr |= urm_pkg::LSR_DR | urm_pkg::LSR_BI;
            rx_push(sysrq_byte);
            sysrq_byte = '0;
          end else if (console_en) begin
            window_open = 1'b1;
          end
        end
        irq_update();
      end
      urm_pkg::REQ_HOST_BYTE: begin
        if (window_open) begin
          rx_push(r.host_byte);
          if (rx_count >= urm_pkg::RX_DEPTH) window_open = 1'b0;
          irq_update();
        end
      end
      urm_pkg::REQ_SYSRQ: sysrq_byte = r.host_byte;
      default: ;
    endcase
    rsp.irq_level = ~iir[0];
    return rsp;
  endfunction

  // responses retire before the request of the same edge is predicted
  always @(posedge clk) begin
    urm_pkg::urm_rsp_t want;
    if (!rst_n) begin
      shadow_reset();
      expected_rsp.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          report("unrequested response", 8'h00, 8'h01);
        end else begin
          want = expected_rsp.pop_front();
          n_checked++;
          if (out_data.read_data !== want.read_data)
            report("read_data", want.read_data, out_data.read_data);
          if (out_data.tx_valid !== want.tx_valid)
            report("tx_valid", {7'b0, want.tx_valid}, {7'b0, out_data.tx_valid});
          if (out_data.tx_byte !== want.tx_byte)
            report("tx_byte", want.tx_byte, out_data.tx_byte);
          if (out_data.irq_level !== want.irq_level)
            report("irq_level", {7'b0, want.irq_level}, {7'b0, out_data.irq_level});
        end
      end
      if (cfg_we) begin
        if (cfg_index == urm_pkg::CFG_CONSOLE_ACTIVE) console_en = cfg_wdata;
        else if (cfg_index == urm_pkg::CFG_SYSRQ_ENABLE) sysrq_en = cfg_wdata;
      end
      if (in_valid && in_ready) expected_rsp.push_back(predict_rsp(in_data));
    end
    pending    <= expected_rsp.size();
    fail_count <= errors;
    checked    <= n_checked;
  end

endmodule

// ===== bench/uart_16550_register_model_tb.sv =====
`timescale 1ns / 100ps
// Top of the UART register model testbench: clock, reset, request stimulus,
// response backpressure and verdict. Depends on urm_pkg, urm_if and urm_checker.
module uart_16550_register_model_tb;

  localparam logic [7:0] MCR_LOOP   = 8'h01 << urm_pkg::MCR_LOOP_BIT;
  localparam logic [7:0] LCR_DLAB   = 8'h01 << urm_pkg::LCR_DLAB_BIT;
  localparam logic [2:0] REQ_TOP    = 3'd7;
  localparam int         LONG_HOLD  = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [urm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic cfg_wdata;

  int  fail_count, pending, checked;
  int  items_sent = 0;
  bit  calm = 1'b0;

  urm_req_if req_if ();
  urm_rsp_if rsp_if ();

  uart_16550_register_model u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  urm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req_if.valid),
    .in_ready   (req_if.ready),
    .in_data    (req_if.data),
    .out_valid  (rsp_if.valid),
    .out_ready  (rsp_if.ready),
    .out_data   (rsp_if.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one request and hold it until taken
  task automatic send(input logic [2:0] t, input logic [2:0] off, input logic [7:0] wd,
                      input logic [7:0] hb);
    int gap;
    req_if.valid <= 1'b1;
    req_if.data  <= urm_pkg::urm_req_t'{req_type: t, reg_offset: off,
                                        write_data: wd, host_byte: hb};
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (t <= urm_pkg::REQ_SYSRQ) items_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic bus_wr(input logic [2:0] off, input logic [7:0] wd);
    send(urm_pkg::REQ_BUS_WRITE, off, wd, 8'($urandom));
  endtask

  task automatic bus_rd(input logic [2:0] off);
    send(urm_pkg::REQ_BUS_READ, off, 8'($urandom), 8'($urandom));
  endtask

  task automatic host_req(input logic [2:0] t, input logic [7:0] hb);
    send(t, 3'($urandom), 8'($urandom), hb);
  endtask

  // stop offering until every response is back
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // both configuration registers, back to back
  task automatic set_config(input logic console_v, input logic sysrq_v);
    cfg_we    <= 1'b1;
    cfg_index <= urm_pkg::CFG_CONSOLE_ACTIVE;
    cfg_wdata <= console_v;
    @(posedge clk);
    cfg_index <= urm_pkg::CFG_SYSRQ_ENABLE;
    cfg_wdata <= sysrq_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mixed sequences until the request count reaches the target
  task automatic run_random(input int target);
    int r, k, n;
    logic [2:0] off;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        // receive burst through a poll window, sometimes past full
        host_req(urm_pkg::REQ_POLL, 8'($urandom));
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        repeat (k) host_req(urm_pkg::REQ_HOST_BYTE, 8'($urandom));
        n = $urandom_range(0, k + 2);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) bus_rd(urm_pkg::OFF_LSR);
          else bus_rd(urm_pkg::OFF_RBR_THR);
        end
      end else if (r < 35) begin
        // loopback transmit into the receive FIFO
        bus_wr(urm_pkg::OFF_MCR, 8'($urandom) | MCR_LOOP);
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(62, 68) : $urandom_range(1, 6);
        repeat (k) bus_wr(urm_pkg::OFF_RBR_THR, 8'($urandom));
        repeat ($urandom_range(0, k + 1)) bus_rd(urm_pkg::OFF_RBR_THR);
        bus_wr(urm_pkg::OFF_MCR, 8'($urandom) & ~MCR_LOOP);
      end else if (r < 45) begin
        // sysrq break injection, zero byte now and then
        host_req(urm_pkg::REQ_SYSRQ, ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
        host_req(urm_pkg::REQ_POLL, 8'($urandom));
        bus_rd(urm_pkg::OFF_LSR);
        repeat ($urandom_range(1, 3)) bus_rd(urm_pkg::OFF_RBR_THR);
      end else if (r < 55) begin
        // interrupt enables, FIFO clears and identity
        bus_wr(urm_pkg::OFF_IER, 8'($urandom));
        if ($urandom_range(0, 1) == 0) bus_wr(urm_pkg::OFF_IIR_FCR, 8'($urandom));
        bus_rd(urm_pkg::OFF_IIR_FCR);
        bus_rd(urm_pkg::OFF_LSR);
      end else if (r < 65) begin
        // divisor latch access
        bus_wr(urm_pkg::OFF_LCR, 8'($urandom) | LCR_DLAB);
        repeat ($urandom_range(1, 3)) begin
          off = ($urandom_range(0, 1) == 0) ? urm_pkg::OFF_RBR_THR : urm_pkg::OFF_IER;
          if ($urandom_range(0, 1) == 0) bus_wr(off, 8'($urandom));
          else bus_rd(off);
        end
        bus_wr(urm_pkg::OFF_LCR, 8'($urandom) & ~LCR_DLAB);
      end else if (r < 87) begin
        // single access, DLAB mostly kept off
        off = 3'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          if (off == urm_pkg::OFF_LCR && $urandom_range(0, 3) != 0)
            bus_wr(off, 8'($urandom) & ~LCR_DLAB);
          else
            bus_wr(off, 8'($urandom));
        end else begin
          bus_rd(off);
        end
      end else if (r < 89) begin
        wait_idle();
      end else begin
        // noise over every request code
        send(3'($urandom_range(0, REQ_TOP)), 3'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // response side: random stalls plus two long hold-offs
  initial begin
    int seg, outs, holds, r;
    logic level;
    outs  = 0;
    holds = 0;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds < 2 && outs >= 150 + holds * 350) begin
        level = 1'b0;
        seg   = LONG_HOLD;
        holds++;
      end else if (calm) begin
        level = 1'b1;
        seg   = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          level = 1'b1;
          seg   = $urandom_range(1, 20);
        end else if (r < 95) begin
          level = 1'b0;
          seg   = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          seg   = $urandom_range(10, 40);
        end
      end
      repeat (seg) begin
        rsp_if.ready <= level;
        @(posedge clk);
        if (rsp_if.valid && rsp_if.ready) outs++;
      end
    end
  end

  // reset, directed requests, then random phases per configuration
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = urm_pkg::CFG_CONSOLE_ACTIVE;
    cfg_wdata    = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values and plain registers
    bus_rd(urm_pkg::OFF_IIR_FCR);
    bus_rd(urm_pkg::OFF_LSR);
    bus_rd(urm_pkg::OFF_MSR);
    bus_wr(urm_pkg::OFF_SCR, 8'hFF);
    bus_rd(urm_pkg::OFF_SCR);
    bus_wr(urm_pkg::OFF_SCR, 8'h00);
    bus_wr(urm_pkg::OFF_IER, 8'hFF);
    bus_rd(urm_pkg::OFF_IER);
    bus_wr(urm_pkg::OFF_RBR_THR, 8'hFF);
    // divisor latch
    bus_wr(urm_pkg::OFF_LCR, 8'h83);
    bus_wr(urm_pkg::OFF_RBR_THR, 8'hFF);
    bus_wr(urm_pkg::OFF_IER, 8'h80);
    bus_rd(urm_pkg::OFF_RBR_THR);
    bus_wr(urm_pkg::OFF_LCR, 8'h03);
    // ignored writes to status registers
    bus_wr(urm_pkg::OFF_LSR, 8'h00);
    bus_wr(urm_pkg::OFF_MSR, 8'hFF);
    // receive window, then empty read
    host_req(urm_pkg::REQ_POLL, 8'h00);
    host_req(urm_pkg::REQ_HOST_BYTE, 8'h00);
    host_req(urm_pkg::REQ_HOST_BYTE, 8'hFF);
    bus_rd(urm_pkg::OFF_RBR_THR);
    bus_rd(urm_pkg::OFF_RBR_THR);
    bus_rd(urm_pkg::OFF_RBR_THR);
    // host byte while closed, then break plus sysrq byte
    host_req(urm_pkg::REQ_HOST_BYTE, 8'h55);
    host_req(urm_pkg::REQ_SYSRQ, 8'h68);
    host_req(urm_pkg::REQ_POLL, 8'hFF);
    bus_rd(urm_pkg::OFF_RBR_THR);
    bus_rd(urm_pkg::OFF_RBR_THR);
    // zero sysrq byte, loopback, unknown code
    host_req(urm_pkg::REQ_SYSRQ, 8'h00);
    host_req(urm_pkg::REQ_POLL, 8'h00);
    bus_wr(urm_pkg::OFF_MCR, urm_pkg::MCR_RESET | MCR_LOOP);
    bus_wr(urm_pkg::OFF_RBR_THR, 8'h3C);
    bus_rd(urm_pkg::OFF_RBR_THR);
    send(REQ_TOP, 3'd7, 8'hFF, 8'hFF);
    wait_idle();

    set_config(1'b0, 1'b0);
    run_random(items_sent + 200);
    wait_idle();
    set_config(1'b1, 1'b0);
    run_random(items_sent + 200);
    wait_idle();
    set_config(1'b0, 1'b1);
    calm = 1'b1;
    run_random(items_sent + 200);
    wait_idle();
    calm = 1'b0;
    set_config(1'b1, 1'b1);
    run_random(items_sent + 220);
    wait_idle();
    repeat (4) @(posedge clk);

    $display("covered %0d requests, %0d responses checked", items_sent, checked);
    $display("four console/sysrq settings, loopback, sysrq breaks and full FIFO bursts");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== uart_16550_register_model.f =====
sv/urm_pkg.sv
sv/urm_if.sv
sv/uart_16550_register_model.sv
bench/urm_checker.sv
bench/uart_16550_register_model_tb.sv
